// File: hdl/crmc_pkg.sv
`timescale 1ns / 1ps
package crmc_pkg;

    localparam int NUM_ENTRIES_DEF   = 16;
    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int KEY_BITS_DEF      = 32;

    localparam int IN_KEY_W   = 32;
    localparam int CFG_DATA_W = 5;
    localparam int CNT_W      = 32;

    localparam logic [1:0] POL_FIFO  = 2'd0;
    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;
    localparam logic [1:0] POL_SPARE = 2'd3;

    localparam logic [1:0] KIND_HIT        = 2'd0;
    localparam logic [1:0] KIND_COMPULSORY = 2'd1;
    localparam logic [1:0] KIND_CAPACITY   = 2'd2;

    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

// File: hdl/crmc_ram.sv
`timescale 1ns / 1ps
module crmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/cache_replacement_miss_classifier.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    access_key
// out      out  out_valid/out_ready  hit, miss_kind, compulsory_total,
//                                    capacity_total, history_overflow
// cfg      in   cfg_we (no wait)     cfg_index, cfg_data
//
// One transaction at a time, run by a sequencer around the key RAM and the
// history RAM (one read per cycle, read data registered). Search reads and
// compares each queue position in turn; an LRU hit shifts each later entry
// down one place; each history scan compares recorded keys in turn until a
// match; clock rotation moves each referenced head entry to the tail.
// Async reset empties the queue and clears counters; no clearing pass.
// A waiting result stalls only the loading of the next result.
module cache_replacement_miss_classifier #(
    parameter int NUM_ENTRIES   = crmc_pkg::NUM_ENTRIES_DEF,
    parameter int HISTORY_DEPTH = crmc_pkg::HISTORY_DEPTH_DEF,
    parameter int KEY_BITS      = crmc_pkg::KEY_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [crmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [crmc_pkg::IN_KEY_W-1:0]       access_key,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [1:0]                          miss_kind,
    output logic [crmc_pkg::CNT_W-1:0]          compulsory_total,
    output logic [crmc_pkg::CNT_W-1:0]          capacity_total,
    output logic                                history_overflow
);

    import crmc_pkg::*;

    localparam int IW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int OW  = $clog2(NUM_ENTRIES + 1);
    localparam int SW  = OW + 1;
    localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_S_RD, ST_S_CMP, ST_L_RD, ST_L_WR, ST_L_LAST,
        ST_H_RD, ST_H_CMP, ST_H_END, ST_EV_CHK, ST_ROT_RD, ST_ROT_WR,
        ST_VIC_RD, ST_VIC_GET, ST_INS, ST_DONE
    } state_t;

    state_t state_reg;

    logic [1:0]            policy_reg;
    logic [CFG_DATA_W-1:0] capacity_reg;
    logic [1:0]            pol_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   victim_reg;
    logic [IW-1:0]         head_reg;
    logic [OW-1:0]         occ_reg;
    logic [OW-1:0]         pos_reg;
    logic [CW-1:0]         hi_reg;
    logic [CW-1:0]         hcount_reg;
    logic                  scan_victim_reg;
    logic                  hfound_reg;
    logic                  rb_reg;
    logic                  hit_reg;
    logic [1:0]            kind_reg;
    logic [CNT_W-1:0]      comp_cnt_reg;
    logic [CNT_W-1:0]      cap_cnt_reg;
    logic                  ovf_reg;
    logic [NUM_ENTRIES-1:0] ref_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [1:0]            out_kind_reg;
    logic [CNT_W-1:0]      out_comp_reg;
    logic [CNT_W-1:0]      out_cap_reg;
    logic                  out_ovf_reg;

    logic [OW-1:0]         cap_eff;
    logic                  k_we;
    logic [IW-1:0]         k_waddr;
    logic [KEY_BITS-1:0]   k_wdata;
    logic [IW-1:0]         k_raddr;
    logic [KEY_BITS-1:0]   k_rdata;
    logic                  h_we;
    logic [HAW-1:0]        h_waddr;
    logic [KEY_BITS-1:0]   h_rdata;
    logic [KEY_BITS-1:0]   scan_target;
    logic [IW-1:0]         slot_pos;
    logic [IW-1:0]         slot_pos1;
    logic [IW-1:0]         slot_occ;
    logic [IW-1:0]         slot_last;
    logic [1:0]            pol_in;

    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h,
                                              input logic [OW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(off);
        if (s >= SW'(NUM_ENTRIES))
        begin
            s = s - SW'(NUM_ENTRIES);
        end
        return IW'(s);
    endfunction

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = OW'(1);
        end
        else if (int'(capacity_reg) > NUM_ENTRIES)
        begin
            cap_eff = OW'(NUM_ENTRIES);
        end
        else
        begin
            cap_eff = OW'(capacity_reg);
        end
    end

    assign pol_in      = (policy_reg == POL_SPARE) ? POL_FIFO : policy_reg;
    assign slot_pos    = slot_of(head_reg, pos_reg);
    assign slot_pos1   = slot_of(head_reg, pos_reg + OW'(1));
    assign slot_occ    = slot_of(head_reg, occ_reg);
    assign slot_last   = slot_of(head_reg, occ_reg - OW'(1));
    assign scan_target = scan_victim_reg ? victim_reg : key_reg;

    always_comb
    begin
        k_we    = 1'b0;
        k_waddr = slot_occ;
        k_wdata = key_reg;
        k_raddr = head_reg;
        unique case (state_reg)
            ST_S_RD:   k_raddr = slot_pos;
            ST_L_RD:   k_raddr = slot_pos1;
            ST_L_WR:
            begin
                k_we    = 1'b1;
                k_waddr = slot_pos;
                k_wdata = k_rdata;
            end
            ST_L_LAST:
            begin
                k_we    = 1'b1;
                k_waddr = slot_last;
            end
            ST_ROT_WR:
            begin
                k_we    = 1'b1;
                k_wdata = k_rdata;
            end
            ST_INS:    k_we = 1'b1;
            default:   k_raddr = head_reg;
        endcase
    end

    assign h_waddr = hcount_reg[HAW-1:0];
    assign h_we    = (state_reg == ST_H_END) && scan_victim_reg && !hfound_reg
                     && (hcount_reg < CW'(HISTORY_DEPTH));

    crmc_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    crmc_ram #(.WIDTH(KEY_BITS), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (victim_reg),
        .raddr (hi_reg[HAW-1:0]),
        .rdata (h_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            policy_reg      <= POL_FIFO;
            capacity_reg    <= CAPACITY_RESET;
            pol_reg         <= POL_FIFO;
            key_reg         <= '0;
            victim_reg      <= '0;
            head_reg        <= '0;
            occ_reg         <= '0;
            pos_reg         <= '0;
            hi_reg          <= '0;
            hcount_reg      <= '0;
            scan_victim_reg <= 1'b0;
            hfound_reg      <= 1'b0;
            rb_reg          <= 1'b0;
            hit_reg         <= 1'b0;
            kind_reg        <= KIND_HIT;
            comp_cnt_reg    <= '0;
            cap_cnt_reg     <= '0;
            ovf_reg         <= 1'b0;
            ref_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_hit_reg     <= 1'b0;
            out_kind_reg    <= KIND_HIT;
            out_comp_reg    <= '0;
            out_cap_reg     <= '0;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_POLICY)
                begin
                    policy_reg <= cfg_data[1:0];
                end
                else
                begin
                    capacity_reg <= cfg_data;
                end
            end

            // in ST_DONE the result register is reloaded below instead
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        key_reg         <= KEY_BITS'(access_key);
                        pol_reg         <= pol_in;
                        pos_reg         <= '0;
                        hi_reg          <= '0;
                        scan_victim_reg <= 1'b0;
                        hit_reg         <= 1'b0;
                        state_reg       <= (occ_reg == '0) ? ST_H_RD : ST_S_RD;
                    end
                end
                ST_S_RD:   state_reg <= ST_S_CMP;
                ST_S_CMP:
                begin
                    if (k_rdata == key_reg)
                    begin
                        hit_reg  <= 1'b1;
                        kind_reg <= KIND_HIT;
                        rb_reg   <= ref_reg[slot_pos];
                        if (pol_reg == POL_CLOCK)
                        begin
                            ref_reg[slot_pos] <= 1'b1;
                        end
                        if (pol_reg == POL_LRU && (SW'(pos_reg) + SW'(1) < SW'(occ_reg)))
                        begin
                            state_reg <= ST_L_RD;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                    else if (pos_reg + OW'(1) == occ_reg)
                    begin
                        state_reg <= ST_H_RD;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + OW'(1);
                        state_reg <= ST_S_RD;
                    end
                end
                ST_L_RD:   state_reg <= ST_L_WR;
                ST_L_WR:
                begin
                    ref_reg[slot_pos] <= ref_reg[slot_pos1];
                    pos_reg           <= pos_reg + OW'(1);
                    state_reg <= (SW'(pos_reg) + SW'(2) < SW'(occ_reg)) ? ST_L_RD : ST_L_LAST;
                end
                ST_L_LAST:
                begin
                    ref_reg[slot_last] <= rb_reg;
                    state_reg          <= ST_DONE;
                end
                ST_H_RD:
                begin
                    if (hi_reg == hcount_reg)
                    begin
                        hfound_reg <= 1'b0;
                        state_reg  <= ST_H_END;
                    end
                    else
                    begin
                        state_reg <= ST_H_CMP;
                    end
                end
                ST_H_CMP:
                begin
                    if (h_rdata == scan_target)
                    begin
                        hfound_reg <= 1'b1;
                        state_reg  <= ST_H_END;
                    end
                    else
                    begin
                        hi_reg    <= hi_reg + CW'(1);
                        state_reg <= ST_H_RD;
                    end
                end
                ST_H_END:
                begin
                    if (!scan_victim_reg)
                    begin
                        if (hfound_reg)
                        begin
                            kind_reg <= KIND_CAPACITY;
                            if (cap_cnt_reg != '1)
                            begin
                                cap_cnt_reg <= cap_cnt_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            kind_reg <= KIND_COMPULSORY;
                            if (comp_cnt_reg != '1)
                            begin
                                comp_cnt_reg <= comp_cnt_reg + CNT_W'(1);
                            end
                        end
                    end
                    else if (!hfound_reg)
                    begin
                        if (hcount_reg < CW'(HISTORY_DEPTH))
                        begin
                            hcount_reg <= hcount_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    state_reg <= ST_EV_CHK;
                end
                ST_EV_CHK:
                begin
                    if (occ_reg >= cap_eff)
                    begin
                        if (pol_reg == POL_CLOCK && ref_reg[head_reg])
                        begin
                            state_reg <= ST_ROT_RD;
                        end
                        else
                        begin
                            state_reg <= ST_VIC_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_INS;
                    end
                end
                ST_ROT_RD: state_reg <= ST_ROT_WR;
                ST_ROT_WR:
                begin
                    // second chance: old head moves to the tail with its bit clear
                    ref_reg[head_reg] <= 1'b0;
                    if (slot_occ != head_reg)
                    begin
                        ref_reg[slot_occ] <= 1'b0;
                    end
                    head_reg          <= slot_of(head_reg, OW'(1));
                    state_reg         <= ST_EV_CHK;
                end
                ST_VIC_RD: state_reg <= ST_VIC_GET;
                ST_VIC_GET:
                begin
                    victim_reg        <= k_rdata;
                    ref_reg[head_reg] <= 1'b0;
                    head_reg          <= slot_of(head_reg, OW'(1));
                    occ_reg           <= occ_reg - OW'(1);
                    scan_victim_reg   <= 1'b1;
                    hi_reg            <= '0;
                    state_reg         <= ST_H_RD;
                end
                ST_INS:
                begin
                    ref_reg[slot_occ] <= 1'b0;
                    occ_reg           <= occ_reg + OW'(1);
                    state_reg         <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_hit_reg   <= hit_reg;
                        out_kind_reg  <= kind_reg;
                        out_comp_reg  <= comp_cnt_reg;
                        out_cap_reg   <= cap_cnt_reg;
                        out_ovf_reg   <= ovf_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign hit              = out_hit_reg;
    assign miss_kind        = out_kind_reg;
    assign compulsory_total = out_comp_reg;
    assign capacity_total   = out_cap_reg;
    assign history_overflow = out_ovf_reg;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
    import crmc_pkg::*;

    localparam int ENTRIES   = NUM_ENTRIES_DEF;
    localparam int HIST_D    = HISTORY_DEPTH_DEF;
    localparam int WATCHDOG  = 20000;
    localparam int DRAIN_CYC = 1200;
    localparam int HOLD_CYC  = 400;
    localparam int N_PHASES  = 10;
    localparam int PER_PHASE = 180;

    typedef struct packed {
        logic             hit;
        logic [1:0]       kind;
        logic [CNT_W-1:0] comp_tot;
        logic [CNT_W-1:0] cap_tot;
        logic             ovf;
    } outcome_t;

    typedef struct {
        logic [31:0] key;
        bit          typed;
        logic        hit;
        logic [1:0]  kind;
    } access_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [IN_KEY_W-1:0]   access_key;
    logic                  out_valid;
    logic                  out_ready;
    logic                  hit;
    logic [1:0]            miss_kind;
    logic [CNT_W-1:0]      compulsory_total;
    logic [CNT_W-1:0]      capacity_total;
    logic                  history_overflow;

    cache_replacement_miss_classifier dut (.*);

    // shadow cache state
    logic [31:0]      sh_keys [ENTRIES];
    logic             sh_ref  [ENTRIES];
    int unsigned      sh_head, sh_occ;
    logic [31:0]      sh_hist [HIST_D];
    int unsigned      sh_hcnt;
    logic [CNT_W-1:0] sh_comp, sh_capm;
    logic             sh_ovf;
    logic [1:0]       sh_pol;
    logic [4:0]       sh_cap;

    outcome_t    pending_outcomes [$];
    access_row_t rows [$];
    int          errors;
    int          mismatches;
    int          idle_cycles;
    int          n_sent, n_recv, n_hits, n_comp, n_capm;
    bit          hold_req;
    bit          no_gaps;
    logic [31:0] key_pool [32];

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned slot_of(int unsigned pos);
        return (sh_head + pos) % ENTRIES;
    endfunction

    function automatic bit seen_evicted(logic [31:0] k);
        for (int i = 0; i < sh_hcnt && i < HIST_D; i++)
            if (sh_hist[i] == k)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic evict_victim(logic [1:0] pol);
        int unsigned src, dst, turns, s;
        logic [31:0] victim;
        if (sh_occ == 0)
            return;
        if (pol == POL_CLOCK)
        begin
            turns = 0;
            while (turns <= sh_occ && sh_ref[slot_of(0)])
            begin
                src = slot_of(0);
                dst = slot_of(sh_occ);
                sh_ref[src] = 1'b0;
                sh_keys[dst] = sh_keys[src];
                sh_ref[dst] = 1'b0;
                sh_head = (sh_head + 1) % ENTRIES;
                turns++;
            end
        end
        s = slot_of(0);
        victim = sh_keys[s];
        sh_ref[s] = 1'b0;
        sh_head = (sh_head + 1) % ENTRIES;
        sh_occ--;
        if (!seen_evicted(victim))
        begin
            if (sh_hcnt < HIST_D)
            begin
                sh_hist[sh_hcnt] = victim;
                sh_hcnt++;
            end
            else
                sh_ovf = 1'b1;
        end
    endtask

    task automatic classify_access(logic [31:0] k, output outcome_t r);
        logic [1:0]  pol;
        int unsigned cap, found, pos;
        logic        rb;
        pol = (sh_pol == POL_SPARE) ? POL_FIFO : sh_pol;
        cap = (sh_cap < 1) ? 1 : ((sh_cap > ENTRIES) ? ENTRIES : sh_cap);
        found = sh_occ;
        for (pos = 0; pos < sh_occ; pos++)
            if (sh_keys[slot_of(pos)] == k)
            begin
                found = pos;
                break;
            end
        r.hit = (found < sh_occ);
        if (r.hit)
        begin
            r.kind = KIND_HIT;
            if (pol == POL_LRU)
            begin
                rb = sh_ref[slot_of(found)];
                for (pos = found; pos + 1 < sh_occ; pos++)
                begin
                    sh_keys[slot_of(pos)] = sh_keys[slot_of(pos + 1)];
                    sh_ref[slot_of(pos)] = sh_ref[slot_of(pos + 1)];
                end
                sh_keys[slot_of(sh_occ - 1)] = k;
                sh_ref[slot_of(sh_occ - 1)] = rb;
            end
            else if (pol == POL_CLOCK)
                sh_ref[slot_of(found)] = 1'b1;
        end
        else
        begin
            if (seen_evicted(k))
            begin
                r.kind = KIND_CAPACITY;
                if (sh_capm != '1)
                    sh_capm++;
            end
            else
            begin
                r.kind = KIND_COMPULSORY;
                if (sh_comp != '1)
                    sh_comp++;
            end
            while (sh_occ >= cap)
                evict_victim(pol);
            sh_keys[slot_of(sh_occ)] = k;
            sh_ref[slot_of(sh_occ)] = 1'b0;
            sh_occ++;
        end
        r.comp_tot = sh_comp;
        r.cap_tot = sh_capm;
        r.ovf = sh_ovf;
    endtask

    task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_POLICY)
            sh_pol = val[1:0];
        else
            sh_cap = val;
    endtask

    task automatic wait_drained();
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    // offer one key; returns with in_valid still high so back-to-back works
    task automatic send_key(logic [31:0] k, output outcome_t r);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        access_key = k;
        do
            @(posedge clk);
        while (!in_ready);
        classify_access(k, r);
        pending_outcomes.push_back(r);
        n_sent++;
    endtask

    // walk the stimulus table; typed rows are also held to their written values
    task automatic run_rows();
        outcome_t r;
        foreach (rows[i])
        begin
            send_key(rows[i].key, r);
            if (rows[i].typed && (r.hit !== rows[i].hit || r.kind !== rows[i].kind))
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("directed row %0d key %h: exp hit %0b kind %0d got hit %0b kind %0d",
                             i, rows[i].key, rows[i].hit, rows[i].kind, r.hit, r.kind);
            end
        end
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return key_pool[$urandom_range(0, 31)];
        else if (sel < 85)
            return key_pool[$urandom_range(0, 31)] ^ (32'h1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    // receiver side
    initial begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (HOLD_CYC) @(negedge clk);
                hold_req = 1'b0;
            end
            n = no_gaps ? 0 : $urandom_range(0, 12);
            if (n > 0)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want, got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{hit, miss_kind, compulsory_total, capacity_total, history_overflow};
            n_recv++;
            if (pending_outcomes.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result transaction: %p", got);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch at result %0d: exp %p got %p", n_recv, want, got);
                end
                if (want.hit)
                    n_hits++;
                else if (want.kind == KIND_CAPACITY)
                    n_capm++;
                else
                    n_comp++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        outcome_t    r;
        logic [1:0]  ph_pol [N_PHASES];
        logic [4:0]  ph_cap [N_PHASES];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_POLICY;
        cfg_data = '0;
        in_valid = 1'b0;
        access_key = '0;
        errors = 0;
        mismatches = 0;
        idle_cycles = 0;
        n_sent = 0;
        n_recv = 0;
        n_hits = 0;
        n_comp = 0;
        n_capm = 0;
        hold_req = 1'b0;
        no_gaps = 1'b0;
        sh_head = 0;
        sh_occ = 0;
        sh_hcnt = 0;
        sh_comp = '0;
        sh_capm = '0;
        sh_ovf = 1'b0;
        sh_pol = POL_FIFO;
        sh_cap = CAPACITY_RESET;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sh_keys[i] = '0;
            sh_ref[i] = 1'b0;
        end
        for (int i = 0; i < 32; i++)
            key_pool[i] = (i < 4) ? 32'(i) : 32'($urandom);
        key_pool[4] = 32'hFFFF_FFFF;
        key_pool[5] = 32'h8000_0000;
        ph_pol = '{POL_FIFO, POL_LRU, POL_CLOCK, POL_SPARE, POL_LRU,
                   POL_CLOCK, POL_FIFO, POL_CLOCK, POL_LRU, POL_CLOCK};
        ph_cap = '{5'd4, 5'd4, 5'd4, 5'd3, 5'd16, 5'd16, 5'd0, 5'd31, 5'd1, 5'd2};
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // reset defaults first, then capacity 2 so evictions come quickly
        rows.push_back('{32'h0000_0000, 1, 1'b0, KIND_COMPULSORY});
        rows.push_back('{32'h0000_0000, 1, 1'b1, KIND_HIT});
        rows.push_back('{32'hFFFF_FFFF, 1, 1'b0, KIND_COMPULSORY});
        rows.push_back('{32'hFFFF_FFFF, 1, 1'b1, KIND_HIT});
        run_rows();
        stop_sending();
        wait_drained();
        write_reg(REG_CAPACITY, 5'd2);
        write_reg(REG_POLICY, CFG_DATA_W'(POL_FIFO));
        rows.delete();
        rows.push_back('{32'hA5A5_0001, 1, 1'b0, KIND_COMPULSORY});
        rows.push_back('{32'hA5A5_0002, 1, 1'b0, KIND_COMPULSORY});
        // 0 and FFFFFFFF evicted here, so they return as capacity misses
        rows.push_back('{32'h0000_0000, 1, 1'b0, KIND_CAPACITY});
        rows.push_back('{32'hFFFF_FFFF, 1, 1'b0, KIND_CAPACITY});
        rows.push_back('{32'h8000_0000, 1, 1'b0, KIND_COMPULSORY});
        rows.push_back('{32'h0000_0001, 0, 1'b0, KIND_HIT});
        rows.push_back('{32'h8000_0000, 1, 1'b1, KIND_HIT});
        run_rows();
        stop_sending();
        wait_drained();
        // clock: referenced entry gets a second chance
        write_reg(REG_POLICY, CFG_DATA_W'(POL_CLOCK));
        rows.delete();
        rows.push_back('{32'h0000_0010, 0, 1'b0, KIND_HIT});
        rows.push_back('{32'h0000_0010, 1, 1'b1, KIND_HIT});
        rows.push_back('{32'h0000_0011, 0, 1'b0, KIND_HIT});
        rows.push_back('{32'h0000_0010, 1, 1'b1, KIND_HIT});
        rows.push_back('{32'h0000_0012, 0, 1'b0, KIND_HIT});
        run_rows();
        stop_sending();
        wait_drained();
        // lru: hit on the older entry keeps it
        write_reg(REG_POLICY, CFG_DATA_W'(POL_LRU));
        rows.delete();
        rows.push_back('{32'h0000_0020, 0, 1'b0, KIND_HIT});
        rows.push_back('{32'h0000_0012, 1, 1'b1, KIND_HIT});
        rows.push_back('{32'h0000_0021, 0, 1'b0, KIND_HIT});
        rows.push_back('{32'h0000_0012, 1, 1'b1, KIND_HIT});
        run_rows();
        stop_sending();
        wait_drained();

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_reg(REG_POLICY, CFG_DATA_W'(ph_pol[p]));
            write_reg(REG_CAPACITY, ph_cap[p]);
            no_gaps = (p % 4 == 3);
            for (int i = 0; i < PER_PHASE; i++)
            begin
                if (p == 2 && i == 20)
                    hold_req = 1'b1;
                send_key(pick_key(), r);
                // one pause with everything drained, mid phase
                if (p == 5 && i == 60)
                begin
                    stop_sending();
                    wait_drained();
                end
            end
            stop_sending();
            wait_drained();
        end

        repeat (DRAIN_CYC) @(negedge clk);
        $display("sent %0d keys over %0d policy/capacity settings", n_sent, N_PHASES + 4);
        $display("results: %0d hits, %0d compulsory, %0d capacity misses, overflow %0b",
                 n_hits, n_comp, n_capm, sh_ovf);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
hdl/crmc_pkg.sv
hdl/crmc_ram.sv
hdl/cache_replacement_miss_classifier.sv
test/tb.sv
